// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a result on the next clock edge.
`define BBA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// Types and constants shared by the block bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int FIELD_REACH    = 4096;
  localparam int BLK_W          = 12;
  localparam int CFG_W          = 13;
  localparam int STATUS_W       = 2;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 16;
  localparam int OUT_PAD_W      = OUT_TDATA_W - BLK_W - STATUS_W;
  localparam int DEF_MAX_BLOCKS = 4096;
  localparam int DEF_WORD_BITS  = 64;
  localparam int BIT_IDX_W      = 6;

  localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(FIELD_REACH);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bba_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_DOUBLE_FREE = 2'd2,
    STAT_RANGE       = 2'd3
  } bba_status_e;

  typedef struct packed {
    logic                 found;
    logic                 all_used;
    logic [BIT_IDX_W-1:0] idx;
  } bba_find_t;

endpackage

`default_nettype wire

// ===== sv/bba_find.sv =====
// Lowest free bit search over one bitmap word, limited to its first span bits.
`timescale 1ns / 1ps
`default_nettype none

module bba_find #(
  parameter int WORD_BITS = bba_pkg::DEF_WORD_BITS
) (
  input  logic [WORD_BITS-1:0]         used_i,
  input  logic [$clog2(WORD_BITS):0]   span_i,
  output logic [WORD_BITS-1:0]         sel_o,
  output bba_pkg::bba_find_t           find_o
);
  import bba_pkg::*;

  localparam int SPAN_W = $clog2(WORD_BITS) + 1;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] low;
  logic [BIT_IDX_W-1:0] idx;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = SPAN_W'(i) < span_i;
    end
  end

  assign avail = ~used_i & mask;
  assign low   = avail & (~avail + 1'b1);

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low[i]) begin
        idx = idx | BIT_IDX_W'(i);
      end
    end
  end

  assign sel_o           = low;
  assign find_o.found    = |avail;
  assign find_o.all_used = &used_i;
  assign find_o.idx      = idx;

endmodule

`default_nettype wire

// ===== sv/block_bitmap_allocator.sv =====
// First-fit block allocator over a used/free bitmap held in a word memory.
// Input stream: tuser is the operation (allocate or free), tdata[11:0] the
// block to free. Output stream: one word per input word, tdata[1:0] status,
// tdata[13:2] allocated block. The register port takes total_blocks at any
// time; write it only while no request is in flight.
// A rejected request (free out of range, or low-water word at the limit)
// goes straight to the output stage. A free finds the word of its block,
// reads it and clears the bit. An allocate reads k bitmap words, one word
// per cycle through the single memory read port.
// A low-water word pointer skips the words known to be full; k counts the
// words read from it up to the one with the lowest free block or the limit,
// and reaches the word count when a run of full words follows the pointer.
// One request is in flight at a time; the next is accepted once the result
// has moved into the output register, even if the receiver still holds it.
// A stalled receiver holds the output word and blocks only the next result.
// Reset: the memory is cleared one word per cycle, every word of it, before
// the first request is accepted. total_blocks
// resets to 4096.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [11:0] block_number
  input  logic                           s_axis_tuser,  // [0] operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [1:0] status, [13:2] allocated_block
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_data_i
);
  import bba_pkg::*;

  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CW         = $clog2(WORD_COUNT + 1);
  localparam int BASE_W     = $clog2(WORD_COUNT * WORD_BITS + 1);
  localparam int CMP_W      = (BASE_W > CFG_W) ? BASE_W : CFG_W;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int LIM_CAP    = (MAX_BLOCKS < FIELD_REACH) ? MAX_BLOCKS : FIELD_REACH;
  localparam int DIV_SH     = BLK_W + BW;
  localparam int DIV_M      = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W     = BLK_W + DIV_SH + 1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [CFG_W-1:0]        total_q;
  logic [CW-1:0]           lo_q, lo_d;
  logic [BASE_W-1:0]       lo_base_q, lo_base_d;
  logic                    chain_q, chain_d;
  logic                    m_tvalid_q, m_tvalid_d;
  logic [CW-1:0]           w_q, w_d;
  logic [BASE_W-1:0]       base_q, base_d;
  logic [BLK_W-1:0]        blk_q, blk_d;
  logic [CW-1:0]           word_q, word_d;
  bba_status_e             res_status_q, res_status_d;
  logic [BLK_W-1:0]        res_block_q, res_block_d;
  logic [OUT_TDATA_W-1:0]  m_tdata_q, m_tdata_d;

  logic [WORD_BITS-1:0]    mem_q [WORD_COUNT];
  logic [WORD_BITS-1:0]    rdata_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [WORD_BITS-1:0]    mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;

  logic [CFG_W-1:0]        lim;
  logic [CMP_W-1:0]        rem;
  logic [BW:0]             span;
  logic [BASE_W-1:0]       nb;
  logic [CW-1:0]           nw;
  logic [PROD_W-1:0]       prod;
  logic [BLK_W-1:0]        quot;
  logic [BASE_W-1:0]       wbase;
  logic [CMP_W-1:0]        rsum;
  logic [BW-1:0]           rbit;
  logic [BW-1:0]           fidx;
  logic [BLK_W-1:0]        blk_in;
  logic                    in_acc;
  logic [WORD_BITS-1:0]    sel;
  bba_find_t               find;

  assign lim    = (total_q > CFG_W'(LIM_CAP)) ? CFG_W'(LIM_CAP) : total_q;
  assign rem    = CMP_W'(lim) - CMP_W'(base_q);
  assign span   = (rem >= CMP_W'(WORD_BITS)) ? (BW + 1)'(WORD_BITS) : rem[BW:0];
  assign nb     = base_q + BASE_W'(WORD_BITS);
  assign nw     = w_q + 1'b1;
  assign prod   = PROD_W'(blk_q) * PROD_W'(DIV_M);
  assign quot   = prod[DIV_SH +: BLK_W];
  assign wbase  = BASE_W'(word_q * WORD_BITS);
  assign rsum   = CMP_W'(blk_q) - CMP_W'(wbase);
  assign rbit   = rsum[BW-1:0];
  assign fidx   = find.idx[BW-1:0];
  assign blk_in = s_axis_tdata[BLK_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign cfg_ready_o   = 1'b1;

  bba_find #(
    .WORD_BITS(WORD_BITS)
  ) u_find (
    .used_i (rdata_q),
    .span_i (span),
    .sel_o  (sel),
    .find_o (find)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    lo_d         = lo_q;
    lo_base_d    = lo_base_q;
    chain_d      = chain_q;
    w_d          = w_q;
    base_d       = base_q;
    blk_d        = blk_q;
    word_d       = word_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    m_tvalid_d   = m_tvalid_q && !m_axis_tready;
    m_tdata_d    = m_tdata_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(WORD_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_block_d = '0;
          if (s_axis_tuser == OP_FREE) begin
            blk_d = blk_in;
            if (CFG_W'(blk_in) >= lim) begin
              res_status_d = STAT_RANGE;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_DIV;
            end
          end else if (CMP_W'(lo_base_q) >= CMP_W'(lim)) begin
            res_status_d = STAT_FULL;
            state_d      = ST_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = lo_q[AW-1:0];
            w_d       = lo_q;
            base_d    = lo_base_q;
            chain_d   = 1'b1;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_DIV: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(quot);
        word_d    = CW'(quot);
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        if (!rdata_q[rbit]) begin
          res_status_d = STAT_DOUBLE_FREE;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = word_q[AW-1:0];
          mem_wdata    = rdata_q & ~(WORD_BITS'(1) << rbit);
          res_status_d = STAT_OK;
          if (word_q < lo_q) begin
            lo_d      = word_q;
            lo_base_d = wbase;
          end
        end
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (find.found) begin
          mem_we       = 1'b1;
          mem_waddr    = w_q[AW-1:0];
          mem_wdata    = rdata_q | sel;
          res_status_d = STAT_OK;
          res_block_d  = BLK_W'(base_q + BASE_W'(fidx));
          if (chain_q) begin
            lo_d      = w_q;
            lo_base_d = base_q;
          end
          state_d = ST_DONE;
        end else begin
          if (chain_q && find.all_used) begin
            lo_d      = nw;
            lo_base_d = nb;
          end else begin
            chain_d = 1'b0;
          end
          if (CMP_W'(nb) >= CMP_W'(lim)) begin
            res_status_d = STAT_FULL;
            state_d      = ST_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = nw[AW-1:0];
            w_d       = nw;
            base_d    = nb;
          end
        end
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {{OUT_PAD_W{1'b0}}, res_block_q, res_status_q};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      total_q    <= TOTAL_RESET;
      lo_q       <= '0;
      lo_base_q  <= '0;
      chain_q    <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      lo_q       <= lo_d;
      lo_base_q  <= lo_base_d;
      chain_q    <= chain_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q          <= w_d;
    base_q       <= base_d;
    blk_q        <= blk_d;
    word_q       <= word_d;
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    m_tdata_q    <= m_tdata_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  `BBA_ASSERT(a_lo_base_match, int'(lo_base_q) == int'(lo_q) * WORD_BITS, "low-water base out of step")
  `BBA_ASSERT(a_alloc_one_bit, (state_q == ST_SCAN && find.found) |-> ($countones(mem_wdata) == $countones(rdata_q) + 1), "allocate must set exactly one bit")
  `BBA_ASSERT_NEXT(a_result_out, state_q == ST_DONE && (!m_tvalid_q || m_axis_tready), m_tvalid_q && state_q == ST_IDLE, "result not presented")

endmodule

`default_nettype wire
